// ===== hdl/cdj_pkg.sv =====
// Constants and the month-offset table shared by the day-number-to-date pipeline.
`default_nettype none
package cdj_pkg;

	// First day number of the Gregorian calendar.
	localparam int unsigned GREG_START  = 2299161;
	localparam int unsigned GREG_OFFSET = 7468865;
	localparam int unsigned GREG_CYCLE  = 146097;

	localparam int unsigned B_OFFSET = 1524;
	localparam int unsigned C_OFFSET = 2442;
	localparam int unsigned C_DIV    = 7305;
	localparam int unsigned D_MUL    = 1461;
	localparam int unsigned E_MUL    = 10000;
	localparam int unsigned E_DIV    = 306001;

	localparam int unsigned YEAR_LATE  = 4716;
	localparam int unsigned YEAR_EARLY = 4715;
	localparam int unsigned MONTH_WRAP = 13;

	// Field widths.
	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int BD_W    = 9;
	localparam int X4_W    = 23;
	localparam int E_W     = 5;

	// Days from the start of the shifted year to the start of month slot e,
	// floor(30.6001 * e). Only slots 4 through 15 occur.
	function automatic logic [BD_W-1:0] month_offset(input logic [3:0] e);
		logic [BD_W-1:0] r;
		case (e)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd30;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd91;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd183;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd336;
			4'd12:   r = 9'd367;
			4'd13:   r = 9'd397;
			4'd14:   r = 9'd428;
			4'd15:   r = 9'd459;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cdj_cdiv.sv =====
// Pipelined divider by a constant: reciprocal estimate, remainder, correction.
`default_nettype none
module cdj_cdiv #(
	parameter int XW = 34,
	parameter int unsigned DIV = 146097,
	parameter int TW = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic                        in_valid,
	input  wire logic [XW-1:0]               in_x,
	input  wire logic [TW-1:0]               in_tag,
	output logic                             out_valid,
	output logic [XW-$clog2(DIV):0]          out_q,
	output logic [TW-1:0]                    out_tag
);
	// DIV is not a power of two, so 2^T < DIV < 2^(T+1).
	localparam int T   = $clog2(DIV) - 1;
	localparam int XTW = XW - T;
	localparam int QW  = XTW;
	localparam int PW  = 2 * XTW;
	localparam int RW  = $clog2(DIV) + 2;
	localparam longint unsigned RECIP = (64'd1 << XW) / DIV;
	localparam logic [XTW-1:0] RECIP_C = RECIP[XTW-1:0];
	localparam logic [RW-1:0] DIV_R  = RW'(DIV);
	localparam logic [RW-1:0] DIV2_R = RW'(2 * DIV);

	logic          v_s1, v_s2, v_s3;
	logic [XW-1:0] x_s1;
	logic [PW-1:0] prod_s1;
	logic [TW-1:0] tag_s1, tag_s2, tag_s3;
	logic [QW-1:0] q0_s2, q_s3;
	logic [RW-1:0] rem_s2;
	logic [QW-1:0] q0;
	logic [XW-1:0] rem_full;

	// The estimate never exceeds the quotient and falls short by at most two.
	assign q0       = prod_s1[PW-1:XTW];
	assign rem_full = x_s1 - XW'(q0) * XW'(DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1    <= in_x;
			prod_s1 <= PW'(in_x[XW-1:T]) * PW'(RECIP_C);
			tag_s1  <= in_tag;
			q0_s2   <= q0;
			rem_s2  <= rem_full[RW-1:0];
			tag_s2  <= tag_s1;
			q_s3    <= q0_s2 + QW'(rem_s2 >= DIV_R) + QW'(rem_s2 >= DIV2_R);
			tag_s3  <= tag_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_q     = q_s3;
	assign out_tag   = tag_s3;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem_s2 < RW'(3 * DIV)))
		else $error("estimate remainder beyond three divisors");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(v_s3) && $stable(q_s3))
		else $error("divider output moved while held");
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (v_s3 == $past(v_s2)))
		else $error("valid lost or repeated in divider");

endmodule
`default_nettype wire

// ===== hdl/calendar_date_from_julian_day.sv =====
// Top level: Julian day number to calendar year, month and day, fully pipelined.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------------
//  day     | day_valid  | day_stall  | day_number
//  date    | date_valid | date_stall | year, month, day_of_month
//
// One item enters per cycle while the output is not stalled; each item passes
// through three constant dividers of three stages each plus the adder stages.
// Reset clears only the valid bits; no clearing pass is needed.
// A stall on the output freezes the whole pipeline in place, so day_stall
// follows date_stall while an item sits in the output register.
`default_nettype none
module calendar_date_from_julian_day #(
	parameter int DAY_NUMBER_BITS = 23
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        day_valid,
	output logic                             day_stall,
	input  wire logic [DAY_NUMBER_BITS-1:0]  day_number,
	output logic                             date_valid,
	input  wire logic                        date_stall,
	output logic signed [cdj_pkg::YEAR_W-1:0] year,
	output logic [cdj_pkg::MONTH_W-1:0]      month,
	output logic [cdj_pkg::DOM_W-1:0]        day_of_month
);
	localparam int N   = DAY_NUMBER_BITS;
	localparam int XA  = N + 2;
	localparam int AW  = XA - $clog2(cdj_pkg::GREG_CYCLE) + 1;
	localparam int BW  = N + 1;
	localparam int XC  = N + 6;
	localparam int CW  = XC - $clog2(cdj_pkg::C_DIV) + 1;
	localparam int DPW = CW + 11;
	localparam int DW  = DPW - 2;
	localparam int YW  = N - 4;
	localparam int BDW = cdj_pkg::BD_W;

	logic advance;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic diva_v, divc_v, dive_v;

	logic [N-1:0]  z_s1;
	logic          greg_s1;
	logic [XA-1:0] x1_s1;
	logic [AW-1:0] alpha;
	logic [N:0]    diva_tag;
	logic [N-1:0]  z_a;
	logic          greg_a;

	logic [BW-1:0] b_s2, b_s3, b_s4, b_c;
	logic [XC-1:0] x2_s3;
	logic [CW-1:0] c_c, c_s4, c_s5, c_s6, c_e;
	logic [DW-1:0] d_s4;
	logic [DPW-1:0] d_prod;
	logic [DW-1:0] bd_full;
	logic [BDW-1:0] bd_s5, bd_s6, bd_e;
	logic [cdj_pkg::X4_W-1:0] x4_s6;
	logic [cdj_pkg::E_W-1:0]  e_q;
	logic [BDW+CW-1:0] dive_tag;

	logic [cdj_pkg::E_W-1:0]     mon_full;
	logic [BDW-1:0]              dom_full;
	logic [cdj_pkg::MONTH_W-1:0] month_s7, month_s8;
	logic [cdj_pkg::DOM_W-1:0]   dom_s7, dom_s8;
	logic signed [YW-1:0]        ytmp_s7;
	logic [YW-1:0]               ylate;
	logic [YW-1:0]               ynext;
	logic [cdj_pkg::YEAR_W-1:0]  year_s8;

	// The whole pipeline moves unless a finished item waits at the output.
	assign advance   = !(vld_s8 && date_stall);
	assign day_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= day_valid;
			vld_s2 <= diva_v;
			vld_s3 <= vld_s2;
			vld_s4 <= divc_v;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= dive_v;
			vld_s8 <= vld_s7;
		end
	end

	// Gregorian correction: alpha = floor((4z - 7468865) / 146097).
	cdj_cdiv #(
		.XW (XA),
		.DIV(cdj_pkg::GREG_CYCLE),
		.TW (N + 1)
	) u_div_alpha (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (vld_s1),
		.in_x     (x1_s1),
		.in_tag   ({greg_s1, z_s1}),
		.out_valid(diva_v),
		.out_q    (alpha),
		.out_tag  (diva_tag)
	);

	assign greg_a = diva_tag[N];
	assign z_a    = diva_tag[N-1:0];

	// c = floor((20b - 2442) / 7305), the year count since the epoch.
	cdj_cdiv #(
		.XW (XC),
		.DIV(cdj_pkg::C_DIV),
		.TW (BW)
	) u_div_year (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (vld_s3),
		.in_x     (x2_s3),
		.in_tag   (b_s3),
		.out_valid(divc_v),
		.out_q    (c_c),
		.out_tag  (b_c)
	);

	assign d_prod  = DPW'(c_c) * DPW'(cdj_pkg::D_MUL);
	assign bd_full = DW'(b_s4) - d_s4;

	// e = floor(10000 (b - d) / 306001), the month slot.
	cdj_cdiv #(
		.XW (cdj_pkg::X4_W),
		.DIV(cdj_pkg::E_DIV),
		.TW (BDW + CW)
	) u_div_month (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (vld_s6),
		.in_x     (x4_s6),
		.in_tag   ({bd_s6, c_s6}),
		.out_valid(dive_v),
		.out_q    (e_q),
		.out_tag  (dive_tag)
	);

	assign bd_e = dive_tag[BDW+CW-1:CW];
	assign c_e  = dive_tag[CW-1:0];

	assign mon_full = (e_q <= cdj_pkg::E_W'(cdj_pkg::MONTH_WRAP))
		? e_q - cdj_pkg::E_W'(1) : e_q - cdj_pkg::E_W'(cdj_pkg::MONTH_WRAP);
	assign dom_full = bd_e - cdj_pkg::month_offset(e_q[3:0]);
	assign ylate    = (mon_full > cdj_pkg::E_W'(2))
		? YW'(cdj_pkg::YEAR_LATE) : YW'(cdj_pkg::YEAR_EARLY);
	assign ynext    = (ytmp_s7[YW-1] || ytmp_s7 == '0)
		? YW'(ytmp_s7) - YW'(1) : YW'(ytmp_s7);

	always_ff @(posedge clk) begin
		if (advance) begin
			z_s1    <= day_number;
			greg_s1 <= (XA'(day_number) >= XA'(cdj_pkg::GREG_START));
			x1_s1   <= (XA'(day_number) << 2) - XA'(cdj_pkg::GREG_OFFSET);

			b_s2 <= greg_a
				? BW'(z_a) + BW'(1) + BW'(alpha) - BW'(alpha >> 2) + BW'(cdj_pkg::B_OFFSET)
				: BW'(z_a) + BW'(cdj_pkg::B_OFFSET);

			b_s3  <= b_s2;
			x2_s3 <= (XC'(b_s2) << 4) + (XC'(b_s2) << 2) - XC'(cdj_pkg::C_OFFSET);

			b_s4 <= b_c;
			c_s4 <= c_c;
			d_s4 <= d_prod[DPW-1:2];

			// b - d always lies between 123 and 488.
			bd_s5 <= bd_full[BDW-1:0];
			c_s5  <= c_s4;

			bd_s6 <= bd_s5;
			c_s6  <= c_s5;
			x4_s6 <= cdj_pkg::X4_W'(bd_s5) * cdj_pkg::X4_W'(cdj_pkg::E_MUL);

			month_s7 <= mon_full[cdj_pkg::MONTH_W-1:0];
			dom_s7   <= dom_full[cdj_pkg::DOM_W-1:0];
			ytmp_s7  <= $signed(YW'(c_e) - ylate);

			// There is no year zero: years at or below zero move down by one.
			month_s8 <= month_s7;
			dom_s8   <= dom_s7;
			year_s8  <= ynext[cdj_pkg::YEAR_W-1:0];
		end
	end

	assign date_valid   = vld_s8;
	assign year         = $signed(year_s8);
	assign month        = month_s8;
	assign day_of_month = dom_s8;

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> (month >= cdj_pkg::MONTH_W'(1) && month <= cdj_pkg::MONTH_W'(12)))
		else $error("month out of range");
	a_dom_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid |-> (day_of_month != '0))
		else $error("day of month is zero");
	a_bd_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (bd_s5 >= BDW'(123) && bd_s5 <= BDW'(488)))
		else $error("day within shifted year out of range");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Julian day number to calendar date converter.
`default_nettype none
module testbench;

	localparam int DAY_NUMBER_BITS = 23;
	localparam longint MAX_DAY = (64'd1 << DAY_NUMBER_BITS) - 1;
	localparam int RANDOM_ITEMS = 1730;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_CYCLES = 2000;

	typedef struct packed {
		logic signed [cdj_pkg::YEAR_W-1:0] year;
		logic [cdj_pkg::MONTH_W-1:0] month;
		logic [cdj_pkg::DOM_W-1:0] dom;
	} calendar_date_t;

	typedef struct packed {
		logic [DAY_NUMBER_BITS-1:0] day;
		calendar_date_t date;
	} pending_date_t;

	typedef struct packed {
		logic [DAY_NUMBER_BITS-1:0] day;
		bit known;
		calendar_date_t date;
	} directed_row_t;

	localparam calendar_date_t NO_DATE = '0;

	// Rows marked known carry a date that is easy to confirm by hand; the rest go
	// through the date predictor.
	directed_row_t directed_rows [22] = '{
		'{23'd0,        1'b1, '{-16'sd4713, 4'd1, 5'd1}},
		'{23'd1,        1'b0, NO_DATE},
		'{23'd4000,     1'b0, NO_DATE},
		'{23'd1721057,  1'b0, NO_DATE},
		'{23'd1721423,  1'b0, NO_DATE},
		'{23'd1721424,  1'b0, NO_DATE},
		'{23'd2299159,  1'b0, NO_DATE},
		'{23'd2299160,  1'b1, '{16'sd1582, 4'd10, 5'd4}},
		'{23'd2299161,  1'b1, '{16'sd1582, 4'd10, 5'd15}},
		'{23'd2299162,  1'b0, NO_DATE},
		'{23'd2415079,  1'b0, NO_DATE},
		'{23'd2415080,  1'b0, NO_DATE},
		'{23'd2451545,  1'b1, '{16'sd2000, 4'd1, 5'd1}},
		'{23'd2451604,  1'b0, NO_DATE},
		'{23'd2451605,  1'b0, NO_DATE},
		'{23'd2460311,  1'b0, NO_DATE},
		'{23'h555555,   1'b0, NO_DATE},
		'{23'h2aaaaa,   1'b0, NO_DATE},
		'{23'h400000,   1'b0, NO_DATE},
		'{23'h3fffff,   1'b0, NO_DATE},
		'{23'd8388606,  1'b0, NO_DATE},
		'{23'd8388607,  1'b0, NO_DATE}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic day_valid = 1'b0;
	logic day_stall;
	logic [DAY_NUMBER_BITS-1:0] day_number = '0;
	logic date_valid;
	logic date_stall = 1'b0;
	logic signed [cdj_pkg::YEAR_W-1:0] year;
	logic [cdj_pkg::MONTH_W-1:0] month;
	logic [cdj_pkg::DOM_W-1:0] day_of_month;

	pending_date_t pending_dates [$];
	int mismatches = 0;
	int days_accepted = 0;
	int dates_received = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit holdoff_active = 1'b0;
	bit holdoff_done = 1'b0;

	calendar_date_from_julian_day #(
		.DAY_NUMBER_BITS(DAY_NUMBER_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.day_valid(day_valid),
		.day_stall(day_stall),
		.day_number(day_number),
		.date_valid(date_valid),
		.date_stall(date_stall),
		.year(year),
		.month(month),
		.day_of_month(day_of_month)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Meeus conversion in exact integer arithmetic; every intermediate value is
	// non-negative, only the year can go below zero.
	function automatic calendar_date_t date_of_day(input logic [DAY_NUMBER_BITS-1:0] day);
		longint unsigned z, shifted, alpha, b, c, d, e, mon, dom;
		longint yr;
		calendar_date_t date;
		z = day;
		if (z < cdj_pkg::GREG_START) begin
			shifted = z;
		end else begin
			alpha = (4 * z - cdj_pkg::GREG_OFFSET) / cdj_pkg::GREG_CYCLE;
			shifted = z + 1 + alpha - alpha / 4;
		end
		b = shifted + cdj_pkg::B_OFFSET;
		c = (20 * b - cdj_pkg::C_OFFSET) / cdj_pkg::C_DIV;
		d = (cdj_pkg::D_MUL * c) / 4;
		e = (cdj_pkg::E_MUL * (b - d)) / cdj_pkg::E_DIV;
		dom = b - d - (cdj_pkg::E_DIV * e) / cdj_pkg::E_MUL;
		mon = (e <= cdj_pkg::MONTH_WRAP) ? e - 1 : e - cdj_pkg::MONTH_WRAP;
		if (mon > 2)
			yr = longint'(c) - longint'(cdj_pkg::YEAR_LATE);
		else
			yr = longint'(c) - longint'(cdj_pkg::YEAR_EARLY);
		// There is no year zero: 1 BC is year -1.
		if (yr <= 0)
			yr = yr - 1;
		date.year = yr[cdj_pkg::YEAR_W-1:0];
		date.month = mon[cdj_pkg::MONTH_W-1:0];
		date.dom = dom[cdj_pkg::DOM_W-1:0];
		return date;
	endfunction

	function automatic logic [DAY_NUMBER_BITS-1:0] random_day_number();
		logic [DAY_NUMBER_BITS-1:0] day;
		case ($urandom_range(0, 5))
			0, 1: day = DAY_NUMBER_BITS'($urandom());
			2: day = DAY_NUMBER_BITS'($urandom_range(1721000, 2600000));
			3: day = DAY_NUMBER_BITS'($urandom_range(cdj_pkg::GREG_START - 800,
				cdj_pkg::GREG_START + 800));
			4: day = DAY_NUMBER_BITS'($urandom_range(0, 4000));
			default: day = DAY_NUMBER_BITS'(MAX_DAY - $urandom_range(0, 4000));
		endcase
		return day;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Offers one day number, holding it until it is taken. Items come in bursts
	// separated by random gaps.
	task automatic offer_day(input logic [DAY_NUMBER_BITS-1:0] day, input bit known,
			input calendar_date_t date);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				day_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		day_valid <= 1'b1;
		day_number <= day;
		do @(posedge clk); while (day_stall);
		pending_dates.push_back('{day, known ? date : date_of_day(day)});
		days_accepted++;
		@(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i])
			offer_day(directed_rows[i].day, directed_rows[i].known, directed_rows[i].date);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			offer_day(random_day_number(), 1'b0, NO_DATE);
		day_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d day numbers (%0d directed rows), %0d dates checked.",
			days_accepted, $size(directed_rows), dates_received);
		$display("Random sender bursts and receiver stalls, plus one %0d-cycle output hold-off%s.",
			HOLDOFF_CYCLES, holdoff_done ? "" : " (not reached)");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// One long output hold-off while the sender keeps offering, so the pipeline
	// fills and backs up to its input.
	initial begin
		wait (days_accepted >= 400);
		@(posedge clk);
		holdoff_active = 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		holdoff_active = 1'b0;
		holdoff_done = 1'b1;
	end

	// Receiver stall pattern: runs of no stall, light and heavy random stalls,
	// and alternating cycles.
	int stall_mode = 0;
	int stall_run = 0;
	always @(negedge clk) begin
		bit pattern_stall;
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = $urandom_range(20, 200);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			0: pattern_stall = 1'b0;
			1: pattern_stall = ($urandom_range(0, 3) == 0);
			2: pattern_stall = ($urandom_range(0, 3) != 0);
			default: pattern_stall = stall_run[0];
		endcase
		date_stall <= holdoff_active || pattern_stall;
	end

	always @(posedge clk) begin
		pending_date_t want;
		if (arst_n && date_valid && !date_stall) begin
			dates_received++;
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("date %0d-%0d-%0d with no day number pending",
					year, month, day_of_month));
			end else begin
				want = pending_dates.pop_front();
				if (year !== want.date.year)
					report_mismatch($sformatf("day %0d: year %0d, expected %0d",
						want.day, year, want.date.year));
				if (month !== want.date.month)
					report_mismatch($sformatf("day %0d: month %0d, expected %0d",
						want.day, month, want.date.month));
				if (day_of_month !== want.date.dom)
					report_mismatch($sformatf("day %0d: day of month %0d, expected %0d",
						want.day, day_of_month, want.date.dom));
			end
		end
	end

	always @(posedge clk) begin
		if ((day_valid && !day_stall) || (date_valid && !date_stall) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("Watchdog: no handshake for %0d cycles, %0d dates outstanding.",
					idle_cycles, pending_dates.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/cdj_pkg.sv
hdl/cdj_cdiv.sv
hdl/calendar_date_from_julian_day.sv
tb/testbench.sv
